[sv/mrc_pkg.sv]
package mrc_pkg;

    localparam int MaxFrameBytes = 256;
    localparam int CntW          = $clog2(MaxFrameBytes + 2);
    localparam int HdrBytes      = 6;
    localparam int HdrIdxW       = $clog2(HdrBytes);

    typedef logic [CntW-1:0] t_cnt;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FC_READ_COILS   = 8'h01;
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
    localparam logic [7:0] FC_WRITE_REG    = 8'h06;
    localparam logic [7:0] ADDR_BROADCAST  = 8'h00;
    localparam logic [7:0] EXC_FN_FLAG     = 8'h80;

    localparam logic [15:0] COIL_QTY_MIN = 16'h0001;
    localparam logic [15:0] COIL_QTY_MAX = 16'h07D0;

    localparam logic [15:0] REG_ANALOG_LAST   = 16'd127;
    localparam logic [15:0] REG_INTEGER_LAST  = 16'd254;
    localparam logic [15:0] REG_DIGITAL_FIRST = 16'd10001;
    localparam logic [15:0] REG_DIGITAL_LAST  = 16'd10038;

    localparam logic [2:0] CLASS_ANALOG   = 3'd0;
    localparam logic [2:0] CLASS_INTEGER  = 3'd1;
    localparam logic [2:0] CLASS_DIGITAL  = 3'd2;
    localparam logic [2:0] CLASS_HARDWARE = 3'd3;
    localparam logic [2:0] CLASS_NONE     = 3'd4;

    localparam logic [2:0] EXC_NONE        = 3'd0;
    localparam logic [2:0] EXC_ILLEGAL_FN  = 3'd1;
    localparam logic [2:0] EXC_ILLEGAL_ADR = 3'd2;
    localparam logic [2:0] EXC_ILLEGAL_VAL = 3'd3;
    localparam logic [2:0] EXC_BUSY        = 3'd6;

    localparam logic [1:0] VERDICT_IGNORE    = 2'd0;
    localparam logic [1:0] VERDICT_FORWARD   = 2'd1;
    localparam logic [1:0] VERDICT_EXCEPTION = 2'd2;
    localparam logic [1:0] VERDICT_ECHO      = 2'd3;

    localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_DEBUG_FN    = 2'd1;
    localparam logic [1:0] CFG_HW_ID_REG   = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic       device_ready;
    } t_req_in;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [7:0]  function_code;
        logic [15:0] register_number;
        logic [15:0] request_value;
        logic [2:0]  variable_class;
        logic [2:0]  exception_code;
        logic [15:0] exception_crc;
    } t_result;

    typedef struct packed {
        logic        drop;
        logic [7:0]  fn;
        logic [15:0] reg_num;
        logic [15:0] value;
        logic        ready;
    } t_frame;

    function automatic logic [15:0] crc_push(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

[sv/mrc_front.sv]
module mrc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrc_pkg::t_req_in i_req,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      i_own_address,
    output logic            o_rec_valid,
    output mrc_pkg::t_frame o_rec,
    input  logic            i_rec_pop
);
    import mrc_pkg::*;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    logic [15:0]    r_crc;
    t_cnt           r_cnt;
    logic [7:0]     r_hdr [HdrBytes];
    logic [7:0]     n_hdr [HdrBytes];
    logic [15:0]    n_crc;
    t_cnt           n_cnt;
    t_frame         r_q [QDepth];
    logic [QAw-1:0] r_wr;
    logic [QAw-1:0] r_rd;
    logic [QAw:0]   r_qcnt;
    t_frame         rec;
    logic           accept;
    logic           wr_rec;

    assign accept = push && !full;
    assign wr_rec = accept && i_req.frame_end;

    always_comb begin
        n_crc = crc_push(r_crc, i_req.rx_byte);
        n_hdr = r_hdr;
        if (r_cnt < t_cnt'(HdrBytes)) begin
            n_hdr[r_cnt[HdrIdxW-1:0]] = i_req.rx_byte;
        end
        n_cnt = (r_cnt <= t_cnt'(MaxFrameBytes)) ? r_cnt + t_cnt'(1) : r_cnt;

        rec.fn      = n_hdr[1];
        rec.reg_num = {n_hdr[2], n_hdr[3]};
        rec.value   = {n_hdr[4], n_hdr[5]};
        rec.ready   = i_req.device_ready;
        rec.drop    = (n_cnt < t_cnt'(4)) || (n_cnt > t_cnt'(MaxFrameBytes))
                    || (n_crc != 16'h0000)
                    || ((n_hdr[0] != i_own_address) && (n_hdr[0] != ADDR_BROADCAST));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (accept) begin
                if (i_req.frame_end) begin
                    r_crc <= CRC_INIT;
                    r_cnt <= '0;
                end else begin
                    r_crc <= n_crc;
                    r_cnt <= n_cnt;
                end
            end
            if (wr_rec) begin
                r_wr <= r_wr + QAw'(1);
            end
            if (i_rec_pop) begin
                r_rd <= r_rd + QAw'(1);
            end
            r_qcnt <= r_qcnt + (QAw+1)'(wr_rec) - (QAw+1)'(i_rec_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hdr <= n_hdr;
        end
        if (wr_rec) begin
            r_q[r_wr] <= rec;
        end
    end

    assign full        = (r_qcnt == (QAw+1)'(QDepth));
    assign o_rec_valid = (r_qcnt != '0);
    assign o_rec       = r_q[r_rd];

endmodule

[sv/mrc_back.sv]
module mrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    input  mrc_pkg::t_frame  i_rec,
    output logic             o_rec_pop,
    input  logic [7:0]       i_own_address,
    input  logic [7:0]       i_debug_function,
    input  logic [15:0]      i_hw_id_register,
    output logic             empty,
    input  logic             pop,
    output mrc_pkg::t_result o_res
);
    import mrc_pkg::*;

    t_result     n_res;
    logic [15:0] n_c2;
    t_result     r_s1_res;
    logic [15:0] r_s1_c2;
    logic        r_s1_v;
    logic        s1_go;
    t_result     out_res;
    t_result     r_oq [2];
    logic        r_owr;
    logic        r_ord;
    logic [1:0]  r_ocnt;
    logic        pop_acc;
    logic        is_coil;
    logic        is_dbg;
    logic [2:0]  cls;
    logic [2:0]  code;

    // classify the frame
    always_comb begin
        is_coil = (i_rec.fn == FC_READ_COILS) || (i_rec.fn == FC_WRITE_COIL);
        is_dbg  = (i_rec.fn == i_debug_function);
        cls     = CLASS_NONE;
        code    = EXC_NONE;
        if (!i_rec.ready) begin
            code = EXC_BUSY;
        end else begin
            if (!is_dbg && !is_coil) begin
                if (i_rec.reg_num > 16'd0 && i_rec.reg_num <= REG_ANALOG_LAST) begin
                    cls = CLASS_ANALOG;
                end else if (i_rec.reg_num > REG_ANALOG_LAST
                             && i_rec.reg_num <= REG_INTEGER_LAST) begin
                    cls = CLASS_INTEGER;
                end else if (i_rec.reg_num >= REG_DIGITAL_FIRST
                             && i_rec.reg_num <= REG_DIGITAL_LAST) begin
                    cls = CLASS_DIGITAL;
                end else if (i_rec.reg_num == i_hw_id_register) begin
                    cls = CLASS_HARDWARE;
                end else begin
                    code = EXC_ILLEGAL_ADR;
                end
            end else if (is_coil) begin
                cls = CLASS_DIGITAL;
            end
            if (i_rec.fn == FC_READ_COILS) begin
                if (i_rec.value < COIL_QTY_MIN || i_rec.value > COIL_QTY_MAX) begin
                    code = EXC_ILLEGAL_VAL;
                end
            end else if (!(i_rec.fn == FC_WRITE_COIL || i_rec.fn == FC_READ_HOLDING
                           || i_rec.fn == FC_WRITE_REG || is_dbg)) begin
                code = EXC_ILLEGAL_FN;
            end
        end

        n_res                 = '0;
        n_res.function_code   = i_rec.fn;
        n_res.register_number = i_rec.reg_num;
        n_res.request_value   = i_rec.value;
        n_res.variable_class  = cls;
        n_res.exception_code  = code;
        if (code != EXC_NONE) begin
            n_res.verdict        = VERDICT_EXCEPTION;
            n_res.variable_class = CLASS_NONE;
        end else if (i_rec.reg_num == 16'd0 || i_rec.fn == 8'd0) begin
            n_res.verdict = VERDICT_ECHO;
        end else begin
            n_res.verdict = VERDICT_FORWARD;
        end
        if (i_rec.drop) begin
            n_res = '0;
        end

        n_c2 = crc_push(crc_push(CRC_INIT, i_own_address), i_rec.fn + EXC_FN_FLAG);
    end

    // finish the reply crc with the exception code
    always_comb begin
        out_res = r_s1_res;
        if (r_s1_res.exception_code != EXC_NONE) begin
            out_res.exception_crc = crc_push(r_s1_c2, {5'b00000, r_s1_res.exception_code});
        end
    end

    assign s1_go     = r_s1_v && (r_ocnt != 2'd2);
    assign o_rec_pop = i_rec_valid && (!r_s1_v || s1_go);
    assign pop_acc   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (o_rec_pop) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_owr <= !r_owr;
            end
            if (pop_acc) begin
                r_ord <= !r_ord;
            end
            r_ocnt <= r_ocnt + 2'(s1_go) - 2'(pop_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_s1_res <= n_res;
            r_s1_c2  <= n_c2;
        end
        if (s1_go) begin
            r_oq[r_owr] <= out_res;
        end
    end

    assign empty = (r_ocnt == 2'd0);
    assign o_res = r_oq[r_ord];

endmodule

[sv/modbus_rtu_request_checker.sv]
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------
// request  | push / full                | i_req  (rx_byte, frame_end, ...)
// result   | empty / pop                | o_res  (verdict ... exception_crc)
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one byte per cycle while full is low; crc and header are registered per byte in the front
// a result passes the front queue, the stage-1 register and the result queue to o_res
// full rises only when four finished frames wait between front and back
// the back stage stalls on a full two-beat result queue; bytes flow until full rises
// synchronous active-low reset; no clearing pass, config takes reset values
module modbus_rtu_request_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrc_pkg::t_req_in  i_req,
    input  logic              push,
    output logic              full,
    output mrc_pkg::t_result  o_res,
    output logic              empty,
    input  logic              pop,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import mrc_pkg::*;

    logic [7:0]  r_own_address;
    logic [7:0]  r_debug_function;
    logic [15:0] r_hw_id_register;
    logic        rec_valid;
    t_frame      rec;
    logic        rec_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address    <= 8'd1;
            r_debug_function <= 8'd100;
            r_hw_id_register <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OWN_ADDRESS: r_own_address    <= i_cfg_data[7:0];
                CFG_DEBUG_FN:    r_debug_function <= i_cfg_data[7:0];
                CFG_HW_ID_REG:   r_hw_id_register <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .push          (push),
        .full          (full),
        .i_own_address (r_own_address),
        .o_rec_valid   (rec_valid),
        .o_rec         (rec),
        .i_rec_pop     (rec_pop)
    );

    mrc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (rec_valid),
        .i_rec            (rec),
        .o_rec_pop        (rec_pop),
        .i_own_address    (r_own_address),
        .i_debug_function (r_debug_function),
        .i_hw_id_register (r_hw_id_register),
        .empty            (empty),
        .pop              (pop),
        .o_res            (o_res)
    );

    a_ignore_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.verdict == VERDICT_IGNORE) |->
        (o_res.function_code == 8'd0 && o_res.register_number == 16'd0
         && o_res.request_value == 16'd0 && o_res.variable_class == 3'd0
         && o_res.exception_code == EXC_NONE && o_res.exception_crc == 16'd0))
        else $error("ignored frame carries nonzero fields");

    a_exc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.verdict == VERDICT_EXCEPTION) |->
        (o_res.exception_code != EXC_NONE && o_res.variable_class == CLASS_NONE))
        else $error("exception reply without code or with class");

    a_fwd_no_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.verdict == VERDICT_FORWARD || o_res.verdict == VERDICT_ECHO)) |->
        (o_res.exception_code == EXC_NONE && o_res.exception_crc == 16'd0))
        else $error("forward or echo carries exception data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

[tb/tb_modbus_rtu_request_checker.sv]
module tb_modbus_rtu_request_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import mrc_pkg::*;

    localparam int         CycleLimit     = 400000;
    localparam int         ShownMismatch  = 40;
    localparam int         PhaseBytes     = 24;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    t_req_in     i_req = '0;
    logic        push = 1'b0;
    logic        full;
    t_result     o_res;
    logic        empty;
    logic        pop = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_OWN_ADDRESS;
    logic [15:0] i_cfg_data = '0;

    modbus_rtu_request_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .push        (push),
        .full        (full),
        .o_res       (o_res),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the block state and registers
    logic [7:0]  own_addr = 8'd1;
    logic [7:0]  debug_fn = 8'd100;
    logic [15:0] hw_reg = 16'd0;
    logic [15:0] frame_crc = CRC_INIT;
    int          frame_len = 0;
    logic [7:0]  hdr [HdrBytes];

    t_req_in     byte_q [$];
    t_result     verdict_q [$];
    logic [7:0]  frame_buf [$];

    bit          byte_taken = 1'b0;
    bit          result_taken = 1'b0;
    int          in_wait = 0;
    int          out_wait = 0;
    bit          in_steady = 1'b0;
    bit          out_steady = 1'b1;

    int          fail_count = 0;
    int          results_seen = 0;
    int          queued_bytes = 0;
    int          queued_frames = 0;
    int          settings_used = 1;
    int          verdict_seen [4];
    int          cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] s;
        s = acc;
        for (int i = 0; i < 8; i++) begin
            if (s[0] ^ d[i]) begin
                s = (s >> 1) ^ CRC_POLY;
            end else begin
                s = s >> 1;
            end
        end
        return s;
    endfunction

    function automatic bit decode_request_byte(input t_req_in b, output t_result r);
        logic [7:0]  fn;
        logic [15:0] rn;
        logic [15:0] qv;
        logic [15:0] c;
        logic [2:0]  code;
        logic [2:0]  cls;
        int          n;
        r = '0;
        frame_crc = crc16_update(frame_crc, b.rx_byte);
        if (frame_len < HdrBytes) begin
            hdr[frame_len] = b.rx_byte;
        end
        if (frame_len <= MaxFrameBytes) begin
            frame_len++;
        end
        if (!b.frame_end) begin
            return 1'b0;
        end
        n = frame_len;
        c = frame_crc;
        frame_crc = CRC_INIT;
        frame_len = 0;
        r.verdict = VERDICT_IGNORE;
        if (n < 4 || n > MaxFrameBytes || c != 16'h0000 ||
            (hdr[0] != own_addr && hdr[0] != ADDR_BROADCAST)) begin
            return 1'b1;
        end
        fn = hdr[1];
        rn = {hdr[2], hdr[3]};
        qv = {hdr[4], hdr[5]};
        code = EXC_NONE;
        cls = CLASS_NONE;
        if (!b.device_ready) begin
            code = EXC_BUSY;
        end else begin
            if (fn == FC_READ_COILS || fn == FC_WRITE_COIL) begin
                cls = CLASS_DIGITAL;
            end else if (fn != debug_fn) begin
                if (rn > 0 && rn <= REG_ANALOG_LAST) begin
                    cls = CLASS_ANALOG;
                end else if (rn > REG_ANALOG_LAST && rn <= REG_INTEGER_LAST) begin
                    cls = CLASS_INTEGER;
                end else if (rn >= REG_DIGITAL_FIRST && rn <= REG_DIGITAL_LAST) begin
                    cls = CLASS_DIGITAL;
                end else if (rn == hw_reg) begin
                    cls = CLASS_HARDWARE;
                end else begin
                    code = EXC_ILLEGAL_ADR;
                end
            end
            if (fn == FC_READ_COILS) begin
                if (qv < COIL_QTY_MIN || qv > COIL_QTY_MAX) begin
                    code = EXC_ILLEGAL_VAL;
                end
            end else if (!(fn == FC_WRITE_COIL || fn == FC_READ_HOLDING ||
                           fn == FC_WRITE_REG || fn == debug_fn)) begin
                code = EXC_ILLEGAL_FN;
            end
        end
        r.function_code = fn;
        r.register_number = rn;
        r.request_value = qv;
        r.exception_code = code;
        if (code != EXC_NONE) begin
            r.verdict = VERDICT_EXCEPTION;
            cls = CLASS_NONE;
            c = crc16_update(CRC_INIT, own_addr);
            c = crc16_update(c, fn + EXC_FN_FLAG);
            r.exception_crc = crc16_update(c, {5'b00000, code});
        end else if (rn == 16'h0000 || fn == 8'h00) begin
            r.verdict = VERDICT_ECHO;
        end else begin
            r.verdict = VERDICT_FORWARD;
        end
        r.variable_class = cls;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        if (fail_count <= ShownMismatch) begin
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 14));
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // request beats
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || byte_taken) begin
            if (in_wait > 0) begin
                push <= 1'b0;
                in_wait--;
            end else if (byte_q.size() > 0) begin
                i_req <= byte_q.pop_front();
                push <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    in_steady = !in_steady;
                end
                in_wait = draw_gap(in_steady);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result beats
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (!pop || result_taken) begin
            if (out_wait > 0) begin
                pop <= 1'b0;
                out_wait--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 19) == 0) begin
                    out_steady = !out_steady;
                end
                out_wait = draw_gap(out_steady);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            byte_taken <= push && !full;
            result_taken <= pop && !empty;
            if (pop && !empty) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict of unexpected result", 16'(o_res.verdict), '0);
                end else begin
                    want = verdict_q.pop_front();
                    verdict_seen[want.verdict]++;
                    check_field("verdict", 16'(o_res.verdict), 16'(want.verdict));
                    check_field("function_code", 16'(o_res.function_code),
                                16'(want.function_code));
                    check_field("register_number", o_res.register_number,
                                want.register_number);
                    check_field("request_value", o_res.request_value, want.request_value);
                    check_field("variable_class", 16'(o_res.variable_class),
                                16'(want.variable_class));
                    check_field("exception_code", 16'(o_res.exception_code),
                                16'(want.exception_code));
                    check_field("exception_crc", o_res.exception_crc, want.exception_crc);
                end
            end
            if (push && !full) begin
                if (decode_request_byte(i_req, want)) begin
                    verdict_q.push_back(want);
                end
            end
        end
    end

    task automatic send_frame(input bit rdy);
        t_req_in it;
        foreach (frame_buf[i]) begin
            it.rx_byte = frame_buf[i];
            it.frame_end = (i == frame_buf.size() - 1);
            it.device_ready = it.frame_end ? rdy : 1'($urandom_range(0, 1));
            byte_q.push_back(it);
        end
        queued_bytes += frame_buf.size();
        queued_frames++;
    endtask

    task automatic seal_frame(input bit good, input bit rdy);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i]) begin
            c = crc16_update(c, frame_buf[i]);
        end
        if (!good) begin
            c ^= 16'h0001 << $urandom_range(0, 15);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        send_frame(rdy);
    endtask

    task automatic request_frame(input logic [7:0] adr, input logic [7:0] fn,
                                 input logic [15:0] rn, input logic [15:0] qv,
                                 input int extra, input bit good, input bit rdy);
        frame_buf.delete();
        frame_buf.push_back(adr);
        frame_buf.push_back(fn);
        frame_buf.push_back(rn[15:8]);
        frame_buf.push_back(rn[7:0]);
        frame_buf.push_back(qv[15:8]);
        frame_buf.push_back(qv[7:0]);
        repeat (extra) frame_buf.push_back(8'($urandom_range(0, 255)));
        seal_frame(good, rdy);
    endtask

    // address byte plus random filler, with or without a valid crc
    task automatic stub_frame(input logic [7:0] adr, input int n, input bit sealed,
                              input bit rdy);
        frame_buf.delete();
        frame_buf.push_back(adr);
        repeat (n - 1) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (sealed) begin
            seal_frame(1'b1, rdy);
        end else begin
            send_frame(rdy);
        end
    endtask

    task automatic random_frame();
        int          kind;
        logic [7:0]  adr;
        logic [7:0]  fn;
        logic [15:0] rn;
        logic [15:0] qv;
        bit          rdy;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: adr = own_addr;
            6, 7:             adr = ADDR_BROADCAST;
            default:          adr = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 6))
            0:       fn = FC_READ_COILS;
            1:       fn = FC_READ_HOLDING;
            2:       fn = FC_WRITE_COIL;
            3:       fn = FC_WRITE_REG;
            4:       fn = debug_fn;
            default: fn = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 13))
            0:       rn = 16'h0000;
            1:       rn = 16'h0001;
            2:       rn = REG_ANALOG_LAST;
            3:       rn = REG_ANALOG_LAST + 16'd1;
            4:       rn = REG_INTEGER_LAST;
            5:       rn = REG_INTEGER_LAST + 16'd1;
            6:       rn = REG_DIGITAL_FIRST - 16'd1;
            7:       rn = REG_DIGITAL_FIRST;
            8:       rn = REG_DIGITAL_LAST;
            9:       rn = REG_DIGITAL_LAST + 16'd1;
            10:      rn = hw_reg;
            11:      rn = 16'($urandom_range(0, 300));
            12:      rn = 16'($urandom_range(REG_DIGITAL_FIRST - 3, REG_DIGITAL_LAST + 3));
            default: rn = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       qv = 16'h0000;
            1:       qv = COIL_QTY_MIN;
            2:       qv = COIL_QTY_MAX;
            3:       qv = COIL_QTY_MAX + 16'd1;
            4:       qv = 16'hFFFF;
            default: qv = 16'($urandom_range(0, 65535));
        endcase
        rdy = $urandom_range(0, 7) != 0;
        if (kind < 70) begin
            request_frame(adr, fn, rn, qv,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0, 1'b1, rdy);
        end else if (kind < 80) begin
            request_frame(adr, fn, rn, qv, 0, 1'b0, rdy);
        end else if (kind < 88) begin
            stub_frame(adr, $urandom_range(2, 3), 1'b1, rdy);
        end else if (kind < 94) begin
            stub_frame(adr, $urandom_range(1, 3), 1'b0, rdy);
        end else begin
            stub_frame(8'($urandom_range(0, 255)), $urandom_range(4, 12), 1'b0, rdy);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_OWN_ADDRESS: own_addr = val[7:0];
            CFG_DEBUG_FN:    debug_fn = val[7:0];
            CFG_HW_ID_REG:   hw_reg = val;
            default:         ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_station(input logic [7:0] adr, input logic [7:0] dbg,
                               input logic [15:0] hw);
        write_reg(CFG_OWN_ADDRESS, {8'h00, adr});
        write_reg(CFG_DEBUG_FN, {8'h00, dbg});
        write_reg(CFG_HW_ID_REG, hw);
        settings_used++;
    endtask

    // waits until every frame has its verdict, then lets the pipeline settle
    task automatic drain();
        @(posedge i_clk);
        while (byte_q.size() != 0 || push || verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          target;
        logic [7:0]  dbg;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values; first frame is full length
        request_frame(own_addr, FC_READ_HOLDING, 16'h0001, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_REG, REG_ANALOG_LAST, 16'hFFFF, 0, 1'b1, 1'b1);
        request_frame(ADDR_BROADCAST, FC_WRITE_REG, REG_ANALOG_LAST + 16'd1, 16'h0000,
                      0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, REG_INTEGER_LAST, 16'h00FF, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, REG_INTEGER_LAST + 16'd1, 16'h0001,
                      0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, REG_DIGITAL_FIRST, 16'h0002, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, REG_DIGITAL_LAST, 16'h0002, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_REG, REG_DIGITAL_FIRST - 16'd1, 16'h0002,
                      0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_REG, REG_DIGITAL_LAST + 16'd1, 16'h0002,
                      0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, 16'h0000, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_COILS, 16'h0010, 16'h0000, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_COILS, 16'h0010, COIL_QTY_MIN, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_COILS, 16'hFFFF, COIL_QTY_MAX, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_COILS, 16'h0010, COIL_QTY_MAX + 16'd1, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_COIL, 16'h0000, 16'hFF00, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_MULTI, 16'h0005, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_MULTI, 16'd300, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(own_addr, 8'h00, 16'h0005, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(own_addr, debug_fn, 16'hFFFF, 16'hFFFF, 0, 1'b1, 1'b1);
        request_frame(own_addr, FC_READ_HOLDING, 16'h0001, 16'h0001, 0, 1'b1, 1'b0);
        request_frame(ADDR_BROADCAST, 8'hFF, 16'h0001, 16'h0001, 0, 1'b1, 1'b0);
        request_frame(own_addr, FC_READ_HOLDING, 16'h0001, 16'h0001, 0, 1'b0, 1'b1);
        request_frame(own_addr + 8'd1, FC_READ_HOLDING, 16'h0001, 16'h0001, 0, 1'b1, 1'b1);
        request_frame(8'hFF, FC_READ_HOLDING, 16'h0001, 16'h0001, 0, 1'b1, 1'b1);
        for (int n = 1; n <= 3; n++) begin
            stub_frame(own_addr, n, 1'b0, 1'b1);
        end
        stub_frame(own_addr, 2, 1'b1, 1'b1);
        stub_frame(own_addr, 3, 1'b1, 1'b1);
        // longest legal frame, then two overlong ones
        request_frame(own_addr, FC_WRITE_REG, 16'h0002, 16'h1234,
                      MaxFrameBytes - 8, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_REG, 16'h0002, 16'h1234,
                      MaxFrameBytes - 7, 1'b1, 1'b1);
        request_frame(own_addr, FC_WRITE_REG, 16'h0002, 16'h1234,
                      MaxFrameBytes - 5, 1'b1, 1'b1);
        drain();

        for (int p = 1; p <= 6; p++) begin
            case (p)
                1: set_station(8'd247, 8'h00, 16'hFFFF);
                2: set_station(8'd1, 8'hFF, REG_DIGITAL_FIRST - 16'd1);
                default: begin
                    case ($urandom_range(0, 4))
                        0:       dbg = FC_READ_COILS;
                        1:       dbg = FC_WRITE_REG;
                        default: dbg = 8'($urandom_range(0, 255));
                    endcase
                    set_station(8'($urandom_range(1, 247)), dbg,
                                16'($urandom_range(0, 65535)));
                end
            endcase
            if (p == 1) begin
                request_frame(own_addr, 8'h00, 16'h0005, 16'h0001, 0, 1'b1, 1'b1);
                request_frame(own_addr, FC_READ_HOLDING, 16'hFFFF, 16'h0001, 0, 1'b1, 1'b1);
                request_frame(own_addr, FC_READ_HOLDING, 16'h0000, 16'h0001, 0, 1'b1, 1'b1);
            end else if (p == 2) begin
                request_frame(own_addr, 8'hFF, 16'h0100, 16'h0001, 0, 1'b1, 1'b1);
                request_frame(own_addr, FC_WRITE_REG, hw_reg, 16'h0001, 0, 1'b1, 1'b1);
            end
            target = queued_bytes + PhaseBytes;
            while (queued_bytes < target) random_frame();
            drain();
        end

        if (verdict_q.size() != 0) begin
            report_mismatch("verdicts never produced", 16'(verdict_q.size()), '0);
        end
        $display("%0d bytes in %0d frames under %0d register settings, %0d verdicts checked",
                 queued_bytes, queued_frames, settings_used, results_seen);
        $display("forwarded %0d, echoed %0d, exception replies %0d, ignored %0d",
                 verdict_seen[VERDICT_FORWARD], verdict_seen[VERDICT_ECHO],
                 verdict_seen[VERDICT_EXCEPTION], verdict_seen[VERDICT_IGNORE]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mrc_pkg.sv
sv/mrc_front.sv
sv/mrc_back.sv
sv/modbus_rtu_request_checker.sv
tb/tb_modbus_rtu_request_checker.sv
